@@ design/ehtst_pkg.sv @@
// Shared types, codes and helpers for the entropy health test.
// No dependencies; imported by the core and the window statistics unit.
package ehtst_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_ONES   = 2'd0,
        CFG_MAX_ONES   = 2'd1,
        CFG_MAX_RUN    = 2'd2,
        CFG_FAIL_LIMIT = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_BUSY      = 3'd0,
        ST_PASS      = 3'd1,
        ST_REPEAT    = 3'd2,
        ST_ONES      = 3'd3,
        ST_RUN       = 3'd4,
        ST_NOT_READY = 3'd5,
        ST_INIT_DONE = 3'd6
    } status_t;

    localparam logic [8:0] MIN_ONES_RST   = 9'd88;
    localparam logic [8:0] MAX_ONES_RST   = 9'd168;
    localparam logic [5:0] MAX_RUN_RST    = 6'd4;
    localparam logic [3:0] FAIL_LIMIT_RST = 4'd3;
    localparam logic [5:0] RUN_SAT        = 6'd63;
    localparam logic [3:0] FAIL_SAT       = 4'd15;

    // Per-beat window statistics handed from the statistics unit to control
    typedef struct packed {
        logic       last;
        logic       rep_hit;
        logic       ones_low;
        logic       ones_high;
        logic       run_long;
        logic [8:0] ones_new;
        logic [8:0] ones_cur;
    } stats_t;

    function automatic logic [3:0] bit_count8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int k = 0; k < 8; k++) begin
            n = n + {3'd0, v[k]};
        end
        return n;
    endfunction

endpackage

@@ design/ehtst_if.sv @@
// Valid/ready channel interfaces for the entropy health test.
// Sample channel in, result channel out; no dependencies.
interface ehtst_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;
    logic       init_ok;

    modport source (output valid, mode, data_byte, init_ok, input ready);
    modport sink (input valid, mode, data_byte, init_ok, output ready);
endinterface

interface ehtst_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic       ready_res;
    logic [3:0] failure_count;
    logic       reinit_request;
    logic [8:0] ones_total;

    modport source (output valid, status, ready_res, failure_count, reinit_request,
                    ones_total, input ready);
    modport sink (input valid, status, ready_res, failure_count, reinit_request,
                  ones_total, output ready);
endinterface

@@ design/entropy_health_test_core.sv @@
// Top level of the entropy health test: configuration, failure tracking,
// source readiness and the result register. Depends on ehtst_pkg, ehtst_if,
// ehtst_window_ram and ehtst_window_stats.
//
// Usage: din carries one beat per item, either a raw entropy byte (mode 0)
// or the outcome of a source initialisation (mode 1). dout returns exactly
// one result beat per accepted item, in order. Configuration is written via
// cfg_we/cfg_index/cfg_data while the block is idle.
// Output: a result is held in the output register from the cycle after its
// item is accepted. Throughput: one item per cycle while dout is ready.
// Window bytes live in a two-bank RAM; the next position's reference byte
// is read ahead from the registered port, and a passing window becomes
// the new reference by swapping bank roles, so no copy is ever made.
// Reset: the source starts not ready, no reference, failure count zero,
// registers at their defaults; no clearing pass is needed, so the first
// item may follow reset at once.
// Stall: while dout is held not ready with a result waiting, din.ready
// drops; items are taken again as soon as the waiting result is taken.
module entropy_health_test_core #(
    parameter int WINDOW_BYTES = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    ehtst_in_if.sink                       din,
    ehtst_out_if.source                    dout,
    input  logic                           cfg_we,
    input  logic [ehtst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ehtst_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ehtst_pkg::*;

    localparam int PW = $clog2(WINDOW_BYTES);
    localparam int AW = PW + 1;

    logic [8:0]    min_ones_reg, max_ones_reg;
    logic [5:0]    max_run_reg;
    logic [3:0]    fail_limit_reg;

    logic          ready_reg, ready_next;
    logic [3:0]    fail_reg, fail_next;
    logic          pend_reg, pend_next;
    logic          refv_reg, refv_next;
    logic          bank_reg, bank_next;
    logic          oval_reg, oval_next;

    status_t       status_reg, status_next;
    logic [8:0]    ones_reg, ones_next;

    logic          accept, take;
    logic [PW-1:0] pos, pos_next;
    logic [7:0]    ref_byte;
    stats_t        stats;
    logic [3:0]    fail_inc;
    status_t       verdict;

    assign din.ready = !oval_reg || dout.ready;
    assign accept    = din.valid && din.ready;
    assign take      = accept && !din.mode && ready_reg;

    ehtst_window_ram #(
        .DEPTH (2 ** AW),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (take),
        .waddr ({~bank_reg, pos}),
        .wdata (din.data_byte),
        .raddr ({bank_next, pos_next}),
        .rdata (ref_byte)
    );

    ehtst_window_stats #(
        .WINDOW_BYTES (WINDOW_BYTES),
        .PW           (PW)
    ) u_stats (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (din.data_byte),
        .ref_valid (refv_reg),
        .ref_byte  (ref_byte),
        .min_ones  (min_ones_reg),
        .max_ones  (max_ones_reg),
        .max_run   (max_run_reg),
        .pos       (pos),
        .pos_next  (pos_next),
        .stats     (stats)
    );

    always_comb
    begin
        fail_inc = (fail_reg == FAIL_SAT) ? fail_reg : fail_reg + 4'd1;

        if (stats.rep_hit)
        begin
            verdict = ST_REPEAT;
        end
        else if (stats.ones_low || stats.ones_high)
        begin
            verdict = ST_ONES;
        end
        else if (stats.run_long)
        begin
            verdict = ST_RUN;
        end
        else
        begin
            verdict = ST_PASS;
        end

        ready_next  = ready_reg;
        fail_next   = fail_reg;
        pend_next   = pend_reg;
        refv_next   = refv_reg;
        bank_next   = bank_reg;
        oval_next   = oval_reg;
        status_next = status_reg;
        ones_next   = ones_reg;

        if (dout.ready)
        begin
            oval_next = 1'b0;
        end

        if (accept)
        begin
            oval_next = 1'b1;
            ones_next = stats.ones_cur;
            if (din.mode)
            begin
                if (pend_reg)
                begin
                    pend_next  = 1'b0;
                    ready_next = din.init_ok;
                    fail_next  = din.init_ok ? 4'd0 : fail_limit_reg;
                end
                else if (!ready_reg && din.init_ok)
                begin
                    ready_next = 1'b1;
                    fail_next  = 4'd0;
                    refv_next  = 1'b0;
                end
                status_next = ready_next ? ST_INIT_DONE : ST_NOT_READY;
            end
            else if (!ready_reg)
            begin
                status_next = ST_NOT_READY;
            end
            else
            begin
                ones_next   = stats.ones_new;
                status_next = ST_BUSY;
                if (stats.last)
                begin
                    status_next = verdict;
                    if (verdict == ST_PASS)
                    begin
                        // the bank just filled becomes the reference
                        fail_next = 4'd0;
                        refv_next = 1'b1;
                        bank_next = ~bank_reg;
                    end
                    else
                    begin
                        fail_next = fail_inc;
                        if (fail_inc >= fail_limit_reg)
                        begin
                            pend_next  = 1'b1;
                            ready_next = 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_ones_reg   <= MIN_ONES_RST;
            max_ones_reg   <= MAX_ONES_RST;
            max_run_reg    <= MAX_RUN_RST;
            fail_limit_reg <= FAIL_LIMIT_RST;
            ready_reg      <= 1'b0;
            fail_reg       <= 4'd0;
            pend_reg       <= 1'b0;
            refv_reg       <= 1'b0;
            bank_reg       <= 1'b0;
            oval_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_MIN_ONES:   min_ones_reg   <= cfg_data[8:0];
                    CFG_MAX_ONES:   max_ones_reg   <= cfg_data[8:0];
                    CFG_MAX_RUN:    max_run_reg    <= cfg_data[5:0];
                    CFG_FAIL_LIMIT: fail_limit_reg <= cfg_data[3:0];
                    default:        min_ones_reg   <= min_ones_reg;
                endcase
            end
            ready_reg <= ready_next;
            fail_reg  <= fail_next;
            pend_reg  <= pend_next;
            refv_reg  <= refv_next;
            bank_reg  <= bank_next;
            oval_reg  <= oval_next;
        end
    end

    // result payload: no reset needed
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        ones_reg   <= ones_next;
    end

    assign dout.valid          = oval_reg;
    assign dout.status         = status_reg;
    assign dout.ones_total     = ones_reg;
    assign dout.ready_res      = ready_reg;
    assign dout.failure_count  = fail_reg;
    assign dout.reinit_request = pend_reg;
endmodule

@@ design/ehtst_window_ram.sv @@
// Two-bank window store: one bank collects the live window, the other holds
// the reference. One write port, one registered read port. No dependencies.
module ehtst_window_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);
    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ design/ehtst_window_stats.sv @@
// Per-byte window statistics: position, one-bit count, run lengths and the
// match against the reference. Depends on ehtst_pkg.
module ehtst_window_stats #(
    parameter int WINDOW_BYTES = 32,
    parameter int PW           = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          data_byte,
    input  logic                ref_valid,
    input  logic [7:0]          ref_byte,
    input  logic [8:0]          min_ones,
    input  logic [8:0]          max_ones,
    input  logic [5:0]          max_run,
    output logic [PW-1:0]       pos,
    output logic [PW-1:0]       pos_next,
    output ehtst_pkg::stats_t   stats
);
    import ehtst_pkg::*;

    localparam int OW   = $clog2(8 * WINDOW_BYTES + 1);
    localparam int CMPW = (OW > 9) ? OW : 9;

    logic [PW-1:0]   pos_reg;
    logic [OW-1:0]   ones_reg, ones_next;
    logic [5:0]      run_reg, run_next;
    logic [5:0]      long_reg, long_next;
    logic            match_reg, match_next;
    logic [7:0]      prev_reg;

    logic [OW-1:0]   ones_sum;
    logic [5:0]      run_upd;
    logic [5:0]      long_upd;
    logic            match_upd;
    logic            last;
    logic [CMPW-1:0] sum_ext, cur_ext;

    always_comb
    begin
        last      = (pos_reg == PW'(WINDOW_BYTES - 1));
        ones_sum  = ones_reg + OW'(bit_count8(data_byte));
        match_upd = match_reg & ref_valid & (ref_byte == data_byte);
        if ((pos_reg != '0) && (data_byte == prev_reg))
        begin
            run_upd = (run_reg < RUN_SAT) ? run_reg + 6'd1 : run_reg;
        end
        else
        begin
            run_upd = 6'd1;
        end
        long_upd = (run_upd > long_reg) ? run_upd : long_reg;

        sum_ext = CMPW'(ones_sum);
        cur_ext = CMPW'(ones_reg);

        stats.last      = last;
        stats.rep_hit   = ref_valid & match_upd;
        stats.ones_low  = sum_ext < CMPW'(min_ones);
        stats.ones_high = sum_ext > CMPW'(max_ones);
        stats.run_long  = long_upd > max_run;
        stats.ones_new  = (sum_ext > CMPW'(511)) ? 9'd511 : sum_ext[8:0];
        stats.ones_cur  = (cur_ext > CMPW'(511)) ? 9'd511 : cur_ext[8:0];

        pos_next   = pos_reg;
        ones_next  = ones_reg;
        run_next   = run_reg;
        long_next  = long_reg;
        match_next = match_reg;
        if (take)
        begin
            if (last)
            begin
                // restart the window
                pos_next   = '0;
                ones_next  = '0;
                run_next   = 6'd1;
                long_next  = 6'd1;
                match_next = 1'b1;
            end
            else
            begin
                pos_next   = pos_reg + PW'(1);
                ones_next  = ones_sum;
                run_next   = run_upd;
                long_next  = long_upd;
                match_next = match_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            ones_reg  <= '0;
            run_reg   <= 6'd1;
            long_reg  <= 6'd1;
            match_reg <= 1'b1;
            prev_reg  <= 8'd0;
        end
        else
        begin
            pos_reg   <= pos_next;
            ones_reg  <= ones_next;
            run_reg   <= run_next;
            long_reg  <= long_next;
            match_reg <= match_next;
            if (take)
            begin
                prev_reg <= data_byte;
            end
        end
    end

    assign pos = pos_reg;
endmodule
